/* hw/rtl/rim_pkg.sv */
// shared types and constants for the rgb image mean squared error block
`default_nettype none

package rim_pkg;

   localparam int MAX_PIXELS = 16777216;

   localparam int CHAN_W = 8;
   localparam int SQ_W   = 2 * CHAN_W;
   localparam int PIX_W  = SQ_W + 2;
   localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
   localparam int SUM_W  = CNT_W + 18;
   localparam int DEN_W  = CNT_W + 2;
   localparam int FRAC_W = 8;
   localparam int MEAN_W = 24;
   localparam int OCNT_W = 25;
   localparam int STEP_W = $clog2(MEAN_W);
   // sum bits from this index upward seed the divider remainder
   localparam int SPLIT  = MEAN_W - FRAC_W;

   typedef struct packed {
      logic [CHAN_W-1:0] first_red;
      logic [CHAN_W-1:0] first_green;
      logic [CHAN_W-1:0] first_blue;
      logic [CHAN_W-1:0] second_red;
      logic [CHAN_W-1:0] second_green;
      logic [CHAN_W-1:0] second_blue;
      logic              last_pixel;
   } req_type;

   typedef struct packed {
      logic [MEAN_W-1:0] mean_error_q8;
      logic [OCNT_W-1:0] pixels_counted;
      logic              overflowed;
   } rsp_type;

   // totals of one image handed from the accumulator to the divider
   typedef struct packed {
      logic             valid;
      logic [SUM_W-1:0] sum;
      logic [CNT_W-1:0] count;
      logic             ovf;
   } launch_type;

   typedef struct packed {
      logic              valid;
      logic [MEAN_W-1:0] mean;
      logic [CNT_W-1:0]  count;
      logic              ovf;
   } div_res_type;

endpackage

`default_nettype wire

/* hw/rtl/rim_lane.sv */
// one channel lane: registered square of the absolute channel difference
`default_nettype none

module rim_lane (
   input  wire logic                      clock,
   input  wire logic                      enable,
   input  wire logic [rim_pkg::CHAN_W-1:0] chan_a,
   input  wire logic [rim_pkg::CHAN_W-1:0] chan_b,
   output logic      [rim_pkg::SQ_W-1:0]   sq_out
);

   logic [rim_pkg::CHAN_W-1:0] diff;
   logic [rim_pkg::SQ_W-1:0]   sq_in;
   logic [rim_pkg::SQ_W-1:0]   sq_ff;

   always_comb begin
      diff  = (chan_a >= chan_b) ? (chan_a - chan_b) : (chan_b - chan_a);
      sq_in = rim_pkg::SQ_W'(diff) * rim_pkg::SQ_W'(diff);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sq_ff <= sq_in;
      end
   end

   assign sq_out = sq_ff;

endmodule

`default_nettype wire

/* hw/rtl/rim_merge.sv */
// merging stage: adds the lane squares into the image totals, saturating the count
`default_nettype none

module rim_merge (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     lane_valid,
   input  wire logic                     lane_last,
   input  wire logic [rim_pkg::SQ_W-1:0] sq_red,
   input  wire logic [rim_pkg::SQ_W-1:0] sq_green,
   input  wire logic [rim_pkg::SQ_W-1:0] sq_blue,
   output rim_pkg::launch_type           launch
);

   logic [rim_pkg::SUM_W-1:0] sum_ff, sum_in, sum_upd;
   logic [rim_pkg::CNT_W-1:0] count_ff, count_in, count_upd;
   logic                      ovf_ff, ovf_in, ovf_upd;
   rim_pkg::launch_type       launch_ff, launch_in;
   logic [rim_pkg::PIX_W-1:0] pix_sum;
   logic                      room;

   always_comb begin
      pix_sum = rim_pkg::PIX_W'(sq_red) + rim_pkg::PIX_W'(sq_green)
              + rim_pkg::PIX_W'(sq_blue);
      room    = count_ff < rim_pkg::CNT_W'(rim_pkg::MAX_PIXELS);

      sum_upd   = room ? (sum_ff + rim_pkg::SUM_W'(pix_sum)) : sum_ff;
      count_upd = room ? (count_ff + rim_pkg::CNT_W'(1)) : count_ff;
      ovf_upd   = ovf_ff | ~room;

      sum_in          = sum_ff;
      count_in        = count_ff;
      ovf_in          = ovf_ff;
      launch_in       = launch_ff;
      launch_in.valid = 1'b0;

      if (lane_valid) begin
         if (lane_last) begin
            // hand the totals over and start the next image clean
            launch_in.valid = 1'b1;
            launch_in.sum   = sum_upd;
            launch_in.count = count_upd;
            launch_in.ovf   = ovf_upd;
            sum_in          = '0;
            count_in        = '0;
            ovf_in          = 1'b0;
         end else begin
            sum_in   = sum_upd;
            count_in = count_upd;
            ovf_in   = ovf_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff    <= '0;
         count_ff  <= '0;
         ovf_ff    <= 1'b0;
         launch_ff <= '0;
      end else begin
         sum_ff    <= sum_in;
         count_ff  <= count_in;
         ovf_ff    <= ovf_in;
         launch_ff <= launch_in;
      end
   end

   assign launch = launch_ff;

endmodule

`default_nettype wire

/* hw/rtl/rim_div.sv */
// iterative restoring divider: one quotient bit per cycle of sum*256 / (3*count)
`default_nettype none

module rim_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rim_pkg::launch_type  launch,
   input  wire logic                 take,
   output rim_pkg::div_res_type      result
);

   typedef enum logic [2:0] {
      DIV_IDLE = 3'b001,
      DIV_RUN  = 3'b010,
      DIV_DONE = 3'b100
   } div_state_type;

   div_state_type              state_ff, state_in;
   logic [rim_pkg::DEN_W-1:0]  rem_ff, rem_in;
   logic [rim_pkg::DEN_W-1:0]  den_ff, den_in;
   logic [rim_pkg::MEAN_W-1:0] dvd_ff, dvd_in;
   logic [rim_pkg::MEAN_W-1:0] quot_ff, quot_in;
   logic [rim_pkg::STEP_W-1:0] step_ff, step_in;
   logic [rim_pkg::CNT_W-1:0]  count_ff, count_in;
   logic                       ovf_ff, ovf_in;
   logic                       zero_ff, zero_in;
   logic [rim_pkg::DEN_W:0]    shifted;
   logic [rim_pkg::DEN_W:0]    trial;

   // quotient stays below 2^24, so the upper dividend bits start below the divisor
   assign shifted = {rem_ff, dvd_ff[rim_pkg::MEAN_W-1]};
   assign trial   = shifted - {1'b0, den_ff};

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      dvd_in   = dvd_ff;
      quot_in  = quot_ff;
      step_in  = step_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      zero_in  = zero_ff;

      unique case (state_ff)
         DIV_IDLE: begin
            if (launch.valid) begin
               rem_in   = launch.sum[rim_pkg::SUM_W-1:rim_pkg::SPLIT];
               dvd_in   = {launch.sum[rim_pkg::SPLIT-1:0], rim_pkg::FRAC_W'(0)};
               den_in   = rim_pkg::DEN_W'({launch.count, 1'b0})
                        + rim_pkg::DEN_W'(launch.count);
               quot_in  = '0;
               step_in  = '0;
               count_in = launch.count;
               ovf_in   = launch.ovf;
               zero_in  = launch.count == '0;
               state_in = DIV_RUN;
            end
         end
         DIV_RUN: begin
            if (!trial[rim_pkg::DEN_W]) begin
               rem_in  = trial[rim_pkg::DEN_W-1:0];
               quot_in = {quot_ff[rim_pkg::MEAN_W-2:0], 1'b1};
            end else begin
               rem_in  = shifted[rim_pkg::DEN_W-1:0];
               quot_in = {quot_ff[rim_pkg::MEAN_W-2:0], 1'b0};
            end
            dvd_in  = {dvd_ff[rim_pkg::MEAN_W-2:0], 1'b0};
            step_in = step_ff + rim_pkg::STEP_W'(1);
            if (step_ff == rim_pkg::STEP_W'(rim_pkg::MEAN_W - 1)) begin
               state_in = DIV_DONE;
            end
         end
         DIV_DONE: begin
            if (take) begin
               state_in = DIV_IDLE;
            end
         end
         default: begin
            state_in = DIV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      dvd_ff   <= dvd_in;
      quot_ff  <= quot_in;
      step_ff  <= step_in;
      count_ff <= count_in;
      ovf_ff   <= ovf_in;
      zero_ff  <= zero_in;
   end

   always_comb begin
      result.valid = state_ff == DIV_DONE;
      result.mean  = zero_ff ? '0 : quot_ff;
      result.count = count_ff;
      result.ovf   = ovf_ff;
   end

endmodule

`default_nettype wire

/* hw/rtl/rgb_image_mse.sv */
// top level: mean squared error of two rgb images, q.8 result per image
// each result passes the lane, merge, divider and output registers in that order
// throughput: one pixel pair per cycle; after the last pair the input stalls while
//   the 24-step divider runs, longer while the output is stalled
// reset: synchronous, active high; clears totals, divider control and output valid
`default_nettype none

module rgb_image_mse (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire rim_pkg::req_type req_data,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output rim_pkg::rsp_type rsp_data
);

   logic                     busy_ff, busy_in;
   logic                     lane_valid_ff;
   logic                     lane_last_ff;
   logic                     req_xfer;
   logic                     take;
   logic                     rsp_valid_ff, rsp_valid_in;
   rim_pkg::rsp_type         rsp_data_ff, rsp_data_in;
   logic [rim_pkg::SQ_W-1:0] sq_red, sq_green, sq_blue;
   rim_pkg::launch_type      launch;
   rim_pkg::div_res_type     div_res;

   assign req_stall = busy_ff;
   assign req_xfer  = req_valid & ~busy_ff;

   rim_lane u_lane_red (
      .clock  (clock),
      .enable (req_xfer),
      .chan_a (req_data.first_red),
      .chan_b (req_data.second_red),
      .sq_out (sq_red)
   );

   rim_lane u_lane_green (
      .clock  (clock),
      .enable (req_xfer),
      .chan_a (req_data.first_green),
      .chan_b (req_data.second_green),
      .sq_out (sq_green)
   );

   rim_lane u_lane_blue (
      .clock  (clock),
      .enable (req_xfer),
      .chan_a (req_data.first_blue),
      .chan_b (req_data.second_blue),
      .sq_out (sq_blue)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_valid_ff <= 1'b0;
      end else begin
         lane_valid_ff <= req_xfer;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         lane_last_ff <= req_data.last_pixel;
      end
   end

   rim_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .lane_valid (lane_valid_ff),
      .lane_last  (lane_last_ff),
      .sq_red     (sq_red),
      .sq_green   (sq_green),
      .sq_blue    (sq_blue),
      .launch     (launch)
   );

   rim_div u_div (
      .clock  (clock),
      .reset  (reset),
      .launch (launch),
      .take   (take),
      .result (div_res)
   );

   // output register frees the divider as soon as the slot is open
   assign take = div_res.valid & (~rsp_valid_ff | ~rsp_stall);

   always_comb begin
      busy_in = busy_ff;
      if (req_xfer && req_data.last_pixel) begin
         busy_in = 1'b1;
      end else if (take) begin
         busy_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (take) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.mean_error_q8  = div_res.mean;
         rsp_data_in.pixels_counted = rim_pkg::OCNT_W'(div_res.count);
         rsp_data_in.overflowed     = div_res.ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_div_while_busy: assert property (@(posedge clock) disable iff (reset)
      div_res.valid |-> busy_ff)
      else $error("divider result present while input is open");

   a_last_blocks: assert property (@(posedge clock) disable iff (reset)
      (lane_valid_ff && lane_last_ff) |-> busy_ff)
      else $error("last pixel in flight without stalling the input");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      launch.valid |-> (launch.count != '0
         && launch.count <= rim_pkg::CNT_W'(rim_pkg::MAX_PIXELS)))
      else $error("image pixel count out of range");

   a_mean_range: assert property (@(posedge clock) disable iff (reset)
      take |=> (rsp_data.mean_error_q8 <= rim_pkg::MEAN_W'(16646400)))
      else $error("mean squared error above the largest possible value");

endmodule

`default_nettype wire
